FILE: design/ttr_pkg.sv
// ----------------------------------------------------------------------------
// ttr_pkg: shared types and constants of the task table
// Payload structs, operation and status codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ttr_pkg;

   localparam int ADDR_W  = 16;
   localparam int CTR_W   = 16;
   localparam int ENTRY_W = ADDR_W + CTR_W;

   localparam logic [CTR_W-1:0]  CTR_STOPPED = 16'hFFFF;
   localparam logic [CTR_W-1:0]  CTR_CLEARED = 16'h0000;
   localparam logic [ADDR_W-1:0] KEY_APPEND  = 16'h0000;

   typedef enum logic [1:0] {
      MODE_REPLACE = 2'd0,
      MODE_REMOVE  = 2'd1,
      MODE_STOP    = 2'd2
   } ttr_mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } ttr_status_type;

   // Source of a table write.
   typedef enum logic [1:0] {
      WR_APPEND  = 2'd0,
      WR_REPLACE = 2'd1,
      WR_STOP    = 2'd2,
      WR_SHIFT   = 2'd3
   } ttr_wsel_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] key_address;
      logic [ADDR_W-1:0] new_address;
   } ttr_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] position;
      logic [5:0] entry_count;
   } ttr_rsp_type;

   typedef struct packed {
      logic           load;
      logic           scan_init;
      logic           scan_inc;
      logic           rd_en;
      logic           rd_next;
      logic           wr_en;
      ttr_wsel_type   wsel;
      logic           size_inc;
      logic           size_dec;
      logic           pos_scan;
      logic           pos_size;
      logic           set_status;
      ttr_status_type status;
   } ttr_cmd_type;

   typedef struct packed {
      logic       append;
      logic       full;
      logic       bad_mode;
      logic       scan_end;
      logic       match;
      logic [1:0] mode;
   } ttr_sts_type;

endpackage

`default_nettype wire

FILE: design/task_table_replace_remove_stop.sv
// ----------------------------------------------------------------------------
// task_table_replace_remove_stop: task table with replace, remove and stop
// Searches the user entries of a task table by address and edits them.
// ----------------------------------------------------------------------------
// Usage:
// A command (mode, key_address, new_address) enters on the req_ channel and
// exactly one result (status, position, entry_count) leaves on the rsp_
// channel. Both use valid/ready; a transfer happens when both are high.
// One command is handled at a time: req_ready is high only while the block
// is idle, and it returns in the cycle after the result transfer.
// An append, a full table or an unused mode goes from decode straight to the
// result. A search reads and compares the user entries in turn until one
// matches or none is left, and a removal then moves each later entry down
// by one. The entry memory has a registered read and is never read and
// written together, so each entry checked costs a read step and a compare
// step, and each entry moved costs a read step and a write step.
// Reset sets the entry count to SYS_TASKS; the entry memory is not cleared.
// A stalled receiver holds the result in its register and blocks new input.
// ----------------------------------------------------------------------------
`default_nettype none

module task_table_replace_remove_stop #(
   parameter int MAX_TASKS = 32,
   parameter int SYS_TASKS = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ttr_pkg::ttr_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output ttr_pkg::ttr_rsp_type      rsp_data
);
   import ttr_pkg::*;

   ttr_cmd_type cmd;
   ttr_sts_type sts;

   ttr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ttr_datapath #(
      .MAX_TASKS (MAX_TASKS),
      .SYS_TASKS (SYS_TASKS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

FILE: design/ttr_datapath.sv
// ----------------------------------------------------------------------------
// ttr_datapath: task table storage and scan datapath
// Holds the entry memory, the entry count, the scan index, the captured
// command and the result registers. Acts on commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ttr_datapath #(
   parameter int MAX_TASKS = 32,
   parameter int SYS_TASKS = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ttr_pkg::ttr_req_type req_data,
   input  wire ttr_pkg::ttr_cmd_type cmd,
   output ttr_pkg::ttr_sts_type      sts,
   output ttr_pkg::ttr_rsp_type      rsp_data
);
   import ttr_pkg::*;

   localparam int SLOTS = MAX_TASKS + SYS_TASKS;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   logic [ENTRY_W-1:0] mem [SLOTS];
   logic [ENTRY_W-1:0] rdata_ff;
   ttr_req_type        req_ff;
   logic [CNT_W-1:0]   size_ff;
   logic [CNT_W-1:0]   size_in;
   logic [CNT_W-1:0]   scan_ff;
   logic [CNT_W-1:0]   scan_nxt;
   logic [IDX_W-1:0]   raddr;
   logic [IDX_W-1:0]   waddr;
   logic [ENTRY_W-1:0] wdata;
   logic [1:0]         status_ff;
   logic [4:0]         pos_ff;

   assign scan_nxt = scan_ff + CNT_W'(1);
   assign raddr    = cmd.rd_next ? scan_nxt[IDX_W-1:0] : scan_ff[IDX_W-1:0];
   assign waddr    = (cmd.wsel == WR_APPEND) ? size_ff[IDX_W-1:0] : scan_ff[IDX_W-1:0];

   always_comb begin
      case (cmd.wsel)
         WR_APPEND:  wdata = {req_ff.new_address, CTR_CLEARED};
         WR_REPLACE: wdata = {req_ff.new_address, CTR_CLEARED};
         WR_STOP:    wdata = {rdata_ff[ENTRY_W-1:CTR_W], CTR_STOPPED};
         WR_SHIFT:   wdata = rdata_ff;
         default:    wdata = rdata_ff;
      endcase
   end

   always_comb begin
      size_in = size_ff;
      if (cmd.size_inc) begin
         size_in = size_ff + CNT_W'(1);
      end else if (cmd.size_dec) begin
         size_in = size_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CNT_W'(SYS_TASKS);
      end else begin
         size_ff <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.scan_init) begin
         scan_ff <= CNT_W'(SYS_TASKS);
      end else if (cmd.scan_inc) begin
         scan_ff <= scan_nxt;
      end
      if (cmd.load) begin
         status_ff <= ST_OK;
         pos_ff    <= 5'd0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
         if (cmd.pos_scan) begin
            pos_ff <= 5'(scan_ff);
         end else if (cmd.pos_size) begin
            pos_ff <= 5'(size_ff);
         end
      end
   end

   assign sts.append   = (req_ff.mode == MODE_REPLACE) && (req_ff.key_address == KEY_APPEND);
   assign sts.full     = (size_ff >= CNT_W'(MAX_TASKS));
   assign sts.bad_mode = (req_ff.mode != MODE_REPLACE) && (req_ff.mode != MODE_REMOVE) &&
                         (req_ff.mode != MODE_STOP);
   assign sts.scan_end = (scan_ff >= size_ff);
   assign sts.match    = (rdata_ff[ENTRY_W-1:CTR_W] == req_ff.key_address);
   assign sts.mode     = req_ff.mode;

   assign rsp_data.status      = status_ff;
   assign rsp_data.position    = pos_ff;
   assign rsp_data.entry_count = 6'(size_ff);

endmodule

`default_nettype wire

FILE: design/ttr_ctrl.sv
// ----------------------------------------------------------------------------
// ttr_ctrl: task table command sequencer
// Decodes a command, steps the search one entry per read and compare pair,
// runs the shift after a removal and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ttr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire ttr_pkg::ttr_sts_type sts,
   output ttr_pkg::ttr_cmd_type      cmd
);
   import ttr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RD,
      S_CMP,
      S_SH_RD,
      S_SH_WR,
      S_RSP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.append) begin
               if (sts.full) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_FULL;
               end else begin
                  cmd.wr_en    = 1'b1;
                  cmd.wsel     = WR_APPEND;
                  cmd.pos_size = 1'b1;
                  cmd.size_inc = 1'b1;
               end
               state_in = S_RSP;
            end else if (sts.bad_mode) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_FOUND;
               state_in       = S_RSP;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            if (sts.scan_end) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_FOUND;
               state_in       = S_RSP;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.match) begin
               cmd.pos_scan = 1'b1;
               case (sts.mode)
                  MODE_REPLACE: begin
                     cmd.wr_en = 1'b1;
                     cmd.wsel  = WR_REPLACE;
                     state_in  = S_RSP;
                  end
                  MODE_REMOVE: begin
                     cmd.size_dec = 1'b1;
                     state_in     = S_SH_RD;
                  end
                  default: begin
                     cmd.wr_en = 1'b1;
                     cmd.wsel  = WR_STOP;
                     state_in  = S_RSP;
                  end
               endcase
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_RD;
            end
         end
         S_SH_RD: begin
            // The count is already reduced, so the scan index below it has a
            // successor to pull down.
            if (sts.scan_end) begin
               state_in = S_RSP;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wsel     = WR_SHIFT;
            cmd.scan_inc = 1'b1;
            state_in     = S_SH_RD;
         end
         S_RSP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
         rsp_valid_ff <= (state_in == S_RSP);
      end
   end

endmodule

`default_nettype wire

FILE: tb/task_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// task_table_checker: result checker for the task table
// Watches the command and result channels, keeps its own copy of the task
// table, works out the result of every accepted command and compares each
// result transfer, field by field, with the oldest expected result.
// ----------------------------------------------------------------------------

module task_table_checker #(
   parameter int MAX_TASKS = 32,
   parameter int SYS_TASKS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  ttr_pkg::ttr_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ttr_pkg::ttr_rsp_type rsp_data,
   output int                   mismatch_count,
   output int                   outstanding
);
   import ttr_pkg::*;

   logic [ADDR_W-1:0] entry_address [MAX_TASKS];
   logic [CTR_W-1:0]  entry_counter [MAX_TASKS];
   int                entry_total;
   logic [4:0]        running_task;

   ttr_rsp_type expected_results [$];
   ttr_rsp_type oldest_result;
   int          errors = 0;

   // Applies one command to the local table and returns the result it gives.
   function automatic ttr_rsp_type apply_command(input ttr_req_type cmd);
      ttr_rsp_type outcome;
      int          hit;
      outcome.status      = ST_OK;
      outcome.position    = '0;
      outcome.entry_count = '0;
      hit = -1;
      for (int i = SYS_TASKS; i < entry_total; i++) begin
         if (hit < 0 && entry_address[i] == cmd.key_address) hit = i;
      end
      if (cmd.mode == MODE_REPLACE && cmd.key_address == KEY_APPEND) begin
         if (entry_total >= MAX_TASKS) begin
            outcome.status = ST_FULL;
         end else begin
            entry_address[entry_total] = cmd.new_address;
            entry_counter[entry_total] = CTR_CLEARED;
            outcome.position = 5'(entry_total);
            entry_total++;
         end
      end else if (hit < 0) begin
         outcome.status = ST_NOT_FOUND;
      end else begin
         case (cmd.mode)
            MODE_REPLACE: begin
               entry_address[hit] = cmd.new_address;
               entry_counter[hit] = CTR_CLEARED;
            end
            MODE_REMOVE: begin
               // Later entries close the gap left by the removed one.
               for (int j = hit; j < entry_total - 1; j++) begin
                  entry_address[j] = entry_address[j + 1];
                  entry_counter[j] = entry_counter[j + 1];
               end
               entry_total--;
               running_task = '0;
            end
            MODE_STOP: begin
               entry_counter[hit] = CTR_STOPPED;
               running_task = '0;
            end
            default: outcome.status = ST_NOT_FOUND;
         endcase
         if (outcome.status == ST_OK) outcome.position = 5'(hit);
      end
      outcome.entry_count = 6'(entry_total);
      return outcome;
   endfunction

   task automatic check_field(input string field, input int predicted, input int actual);
      if (predicted != actual) begin
         $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                  $time, field, predicted, actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         entry_total  = SYS_TASKS;
         running_task = '0;
         expected_results.delete();
      end else begin
         // A result never belongs to a command accepted in the same cycle,
         // so the result side is handled first.
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: unexpected result: expected none, actual %0d/%0d/%0d",
                        $time, rsp_data.status, rsp_data.position,
                        rsp_data.entry_count);
               errors++;
            end else begin
               oldest_result = expected_results.pop_front();
               check_field("status", oldest_result.status, rsp_data.status);
               check_field("position", oldest_result.position, rsp_data.position);
               check_field("entry_count", oldest_result.entry_count,
                           rsp_data.entry_count);
            end
         end
         if (req_valid && req_ready) expected_results.push_back(apply_command(req_data));
      end
      mismatch_count <= errors;
      outstanding    <= expected_results.size();
   end

endmodule

FILE: tb/task_table_replace_remove_stop_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// task_table_replace_remove_stop_test: testbench of the task table
// Sends a directed series of commands and then random commands in phases
// that alternately fill and drain the table, with random gaps on both
// channels except in a calm stretch. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------

module task_table_replace_remove_stop_test;
   import ttr_pkg::*;

   localparam int MAX_TASKS    = 32;
   localparam int SYS_TASKS    = 2;
   localparam int RANDOM_ITEMS = 1600;
   localparam int PHASE_ITEMS  = 150;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int SETTLE       = 150;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ttr_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ttr_rsp_type rsp_data;
   bit          calm      = 1'b0;
   int          mismatch_count;
   int          outstanding;

   task_table_replace_remove_stop #(
      .MAX_TASKS(MAX_TASKS),
      .SYS_TASKS(SYS_TASKS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   task_table_checker #(
      .MAX_TASKS(MAX_TASKS),
      .SYS_TASKS(SYS_TASKS)
   ) table_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 13);
   end

   // Mostly a small set of addresses so that searches hit often; the rest
   // are fully random so that every address bit toggles.
   function automatic logic [ADDR_W-1:0] pick_address();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h0001;
         3: return 16'h8000;
         4: return 16'h1234;
         5: return 16'h5A5A;
         6: return 16'hA5A5;
         7: return 16'h00FF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic ttr_req_type command(input logic [1:0] mode,
                                           input logic [ADDR_W-1:0] key,
                                           input logic [ADDR_W-1:0] fresh);
      ttr_req_type cmd;
      cmd.mode        = mode;
      cmd.key_address = key;
      cmd.new_address = fresh;
      return cmd;
   endfunction

   // Filling phases favor appends, draining phases favor removals.
   function automatic ttr_req_type random_command(input bit filling);
      ttr_req_type cmd;
      int          roll;
      roll = $urandom_range(0, 99);
      cmd.key_address = pick_address();
      cmd.new_address = pick_address();
      if (roll < (filling ? 45 : 15)) begin
         cmd.mode        = MODE_REPLACE;
         cmd.key_address = KEY_APPEND;
      end else if (roll < (filling ? 65 : 30)) begin
         cmd.mode = MODE_REPLACE;
      end else if (roll < (filling ? 80 : 75)) begin
         cmd.mode = MODE_REMOVE;
      end else if (roll < 96) begin
         cmd.mode = MODE_STOP;
      end else begin
         cmd.mode = MODE_UNUSED;
      end
      return cmd;
   endfunction

   // Valid stays high from one command to the next unless a gap is taken.
   task automatic send_command(input ttr_req_type cmd);
      if (!calm && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 13);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int wait_cycles;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Searches on an empty user area, including key zero and the unused mode.
      send_command(command(MODE_REMOVE, 16'h1234, 16'h0000));
      send_command(command(MODE_STOP, 16'h0000, 16'hFFFF));
      send_command(command(MODE_REPLACE, 16'h0005, 16'h0000));
      send_command(command(MODE_UNUSED, 16'h0000, 16'h0000));
      // Appends, with a duplicate address so that the first match wins, then edits of the filled table.
      send_command(command(MODE_REPLACE, KEY_APPEND, 16'h0000));
      send_command(command(MODE_REPLACE, KEY_APPEND, 16'hFFFF));
      send_command(command(MODE_REPLACE, KEY_APPEND, 16'h1234));
      send_command(command(MODE_REPLACE, KEY_APPEND, 16'h1234));
      send_command(command(MODE_REPLACE, 16'h1234, 16'hABCD));
      send_command(command(MODE_STOP, 16'hFFFF, 16'h0000));
      send_command(command(MODE_STOP, 16'h0000, 16'h0000));
      send_command(command(MODE_REMOVE, 16'h0000, 16'h0000));
      send_command(command(MODE_REMOVE, 16'h1234, 16'hFFFF));
      send_command(command(MODE_REPLACE, 16'hFFFF, 16'h0000));
      send_command(command(MODE_REMOVE, 16'h0000, 16'h0000));
      send_command(command(MODE_REPLACE, 16'h9999, 16'h5555));
      send_command(command(MODE_UNUSED, 16'hFFFF, 16'hFFFF));
      send_command(command(MODE_UNUSED, 16'hABCD, 16'h0000));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm <= (n >= 700 && n < 1000);
         send_command(random_command((n / PHASE_ITEMS) % 2 == 0));
      end
      req_valid <= 1'b0;
      @(posedge clock);

      wait_cycles = 0;
      while (outstanding != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (outstanding != 0) begin
         $display("%0t ns: %0d results never arrived", $time, outstanding);
         $display("end of test: mismatches");
      end else begin
         repeat (SETTLE) @(posedge clock);
         if (mismatch_count == 0 && outstanding == 0) begin
            $display("end of test: clean");
         end else begin
            $display("end of test: mismatches");
         end
      end
      $finish;
   end

   initial begin
      #15ms;
      $display("%0t ns: run did not finish in time", $time);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
design/ttr_pkg.sv
design/ttr_datapath.sv
design/ttr_ctrl.sv
design/task_table_replace_remove_stop.sv
tb/task_table_checker.sv
tb/task_table_replace_remove_stop_test.sv
